@@ hw/rtl/prbd_pkg.sv @@
// ----------------------------------------------------------------------------
// prbd_pkg
// shared widths, constants, codes and helpers of the pulse-rate beat detector
// ----------------------------------------------------------------------------
package prbd_pkg;

    // field widths
    localparam int SAMPLE_W   = 18;
    localparam int TIME_W     = 32;
    localparam int THR_W      = 24;
    localparam int MIN_W      = 16;
    localparam int ALPHA_W    = 7;
    localparam int MD_W       = 24;
    localparam int BPM_W      = 16;

    // datapath widths
    localparam int DC_W       = 24;            // dc state, saturated
    localparam int FILT_W     = DC_W + 1;      // filter output
    localparam int WSUM_W     = DC_W + 2;      // sample plus feedback
    localparam int WIN_LEN    = 16;
    localparam int POS_W      = $clog2(WIN_LEN);
    localparam int FILL_W     = $clog2(WIN_LEN + 1);
    localparam int SUM_W      = FILT_W + POS_W + 1;
    localparam int PROD_W     = DC_W + ALPHA_W;
    localparam int DIVD_W     = PROD_W;        // serial divider dividend
    localparam int DIVS_W     = 16;            // serial divider divisor
    localparam int MUL_CNT_W  = $clog2(ALPHA_W);
    localparam int DIV_CNT_W  = $clog2(DIVD_W);

    // constants
    localparam int DC_DIVISOR = 100;
    localparam int BPM_NUM    = 60000;
    localparam int MIN_RST    = 300;
    localparam int ALPHA_RST  = 95;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_MIN_INTERVAL = 2'd1,
        CFG_ALPHA        = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DCDIV,
        ST_WIN,
        ST_MEAN,
        ST_DET,
        ST_BPM,
        ST_DONE
    } t_state;

    // clamp to 24-bit signed
    function automatic logic signed [DC_W-1:0] sat_s24(input logic signed [31:0] v);
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        hi = 32'sd8388607;
        lo = -32'sd8388608;
        if (v > hi) begin
            return DC_W'(hi);
        end else if (v < lo) begin
            return DC_W'(lo);
        end
        return DC_W'(v);
    endfunction

endpackage

@@ hw/rtl/prbd_mul.sv @@
// ----------------------------------------------------------------------------
// prbd_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module prbd_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [prbd_pkg::ALPHA_W-1:0]   i_mplier,
    input  logic [prbd_pkg::DC_W-1:0]      i_mcand,
    output logic [prbd_pkg::PROD_W-1:0]    o_prod,
    output logic                           o_done
);
    import prbd_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [ALPHA_W-1:0]   r_mplier;
    logic [PROD_W-1:0]    r_mcand;
    logic [PROD_W-1:0]    r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(ALPHA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mplier <= i_mplier;
            r_mcand  <= PROD_W'(i_mcand);
            r_acc    <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mplier <= r_mplier >> 1;
            r_mcand  <= r_mcand << 1;
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

@@ hw/rtl/prbd_div.sv @@
// ----------------------------------------------------------------------------
// prbd_div
// restoring radix-2 divider, one quotient bit per cycle, unsigned operands
// ----------------------------------------------------------------------------
module prbd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [prbd_pkg::DIVD_W-1:0]   i_dividend,
    input  logic [prbd_pkg::DIVS_W-1:0]   i_divisor,
    output logic [prbd_pkg::DIVD_W-1:0]   o_quot,
    output logic                          o_done
);
    import prbd_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVD_W-1:0]    r_quo;
    logic [DIVS_W-1:0]    r_rem;
    logic [DIVS_W-1:0]    r_dvs;

    logic [DIVS_W:0]      rem_sh;
    logic [DIVS_W:0]      rem_sub;
    logic                 q_bit;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIVD_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        q_bit   = (rem_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
        end
    end

    assign o_quot = r_quo;
    assign o_done = r_done;

endmodule

@@ hw/rtl/prbd_win.sv @@
// ----------------------------------------------------------------------------
// prbd_win
// moving-window store with running sum and fill count
// ----------------------------------------------------------------------------
module prbd_win (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr,
    input  logic signed [prbd_pkg::FILT_W-1:0]  i_data,
    output logic signed [prbd_pkg::SUM_W-1:0]   o_sum,
    output logic        [prbd_pkg::FILL_W-1:0]  o_fill
);
    import prbd_pkg::*;

    logic signed [FILT_W-1:0] r_store [WIN_LEN];
    logic signed [SUM_W-1:0]  r_sum;
    logic [POS_W-1:0]         r_pos;
    logic [FILL_W-1:0]        r_fill;

    logic signed [SUM_W-1:0]  n_sum;

    // drop the oldest value, add the newest
    assign n_sum = r_sum - SUM_W'(r_store[r_pos]) + SUM_W'(i_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN_LEN; k++) begin
                r_store[k] <= '0;
            end
            r_sum  <= '0;
            r_pos  <= '0;
            r_fill <= '0;
        end else if (i_wr) begin
            r_store[r_pos] <= i_data;
            r_sum          <= n_sum;
            r_pos          <= (r_pos == POS_W'(WIN_LEN - 1)) ? '0 : r_pos + 1'b1;
            if (r_fill != FILL_W'(WIN_LEN)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    assign o_sum  = r_sum;
    assign o_fill = r_fill;

endmodule

@@ hw/rtl/pulse_rate_beat_detector_top.sv @@
// ----------------------------------------------------------------------------
// pulse_rate_beat_detector_top
// optical pulse beat detector: dc removal, moving mean, peak and rate output
// ----------------------------------------------------------------------------
// One word in gives one word out. Each red sample runs through a leaky dc
// filter (alpha/100 feedback), a 16-deep moving mean, and a threshold peak
// detector that reports a beat and 60000/interval beats per minute. The block
// works on one word at a time: each word runs the multiplier and two divides,
// a third when a beat is reported, plus any wait for the output register.
// The work is done by a bit-serial multiplier and one shared
// radix-2 divider used for the /100 of the dc filter, the window
// mean and, on a beat, the rate. A new word is taken as soon as the previous
// one is in the output register, even while that result waits.
// Configuration writes are taken at any time (ready is tied high) and must
// only happen while the block is idle.
// ----------------------------------------------------------------------------
module pulse_rate_beat_detector_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [prbd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [prbd_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // sample input
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [prbd_pkg::SAMPLE_W-1:0]          i_red_sample,
    input  logic [prbd_pkg::TIME_W-1:0]            i_time_ms,
    // result output
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [prbd_pkg::MD_W-1:0]       o_mean_diff,
    output logic                                   o_beat,
    output logic [prbd_pkg::BPM_W-1:0]             o_beats_per_minute
);
    import prbd_pkg::*;

    // configuration registers
    logic signed [THR_W-1:0] r_thr;
    logic [MIN_W-1:0]        r_min;
    logic [ALPHA_W-1:0]      r_alpha;

    // sequencer state
    t_state r_state;
    t_state n_state;

    // per-word working registers
    logic [SAMPLE_W-1:0]      r_sample;
    logic [TIME_W-1:0]        r_time;
    logic signed [FILT_W-1:0] r_filt;
    logic signed [MD_W-1:0]   r_md;
    logic                     r_beat;
    logic [BPM_W-1:0]         r_bpm;

    // detector state
    logic signed [DC_W-1:0]   r_dc_prev;
    logic                     r_armed;
    logic [TIME_W-1:0]        r_last;

    // output register
    logic                     r_out_valid;
    logic signed [MD_W-1:0]   r_out_md;
    logic                     r_out_beat;
    logic [BPM_W-1:0]         r_out_bpm;

    // unit hookup
    logic                     in_acc;
    logic                     mul_start;
    logic [DC_W-1:0]          dc_mag;
    logic [PROD_W-1:0]        mul_prod;
    logic                     mul_done;
    logic                     div_start;
    logic [DIVD_W-1:0]        div_dividend;
    logic [DIVS_W-1:0]        div_divisor;
    logic [DIVD_W-1:0]        div_quot;
    logic                     div_done;
    logic                     win_wr;
    logic signed [SUM_W-1:0]  win_sum;
    logic [FILL_W-1:0]        win_fill;
    logic                     out_free;

    // dc filter arithmetic
    logic signed [FILT_W-1:0] fb_mag;
    logic signed [FILT_W-1:0] fb;
    logic signed [WSUM_W-1:0] w_raw;
    logic signed [DC_W-1:0]   w_sat;
    logic signed [FILT_W-1:0] filt;

    // mean arithmetic
    logic [SUM_W-1:0]         sum_mag;
    logic signed [SUM_W-1:0]  mean_mag;
    logic signed [SUM_W-1:0]  mean;
    logic signed [SUM_W:0]    md_raw;
    logic signed [MD_W-1:0]   md;

    // detection
    logic                     rise;
    logic [MIN_W-1:0]         delta;
    logic                     take_beat;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;

    // magnitude of dc state for the unsigned multiplier
    assign dc_mag = r_dc_prev[DC_W-1] ? DC_W'(-r_dc_prev) : DC_W'(r_dc_prev);

    // feedback = sign(dc_prev) * (|alpha*dc_prev| / 100), truncates toward zero
    always_comb begin
        fb_mag = signed'(div_quot[FILT_W-1:0]);
        fb     = r_dc_prev[DC_W-1] ? -fb_mag : fb_mag;
        w_raw  = WSUM_W'(signed'({1'b0, r_sample})) + WSUM_W'(fb);
        w_sat  = sat_s24(32'(w_raw));
        filt   = FILT_W'(w_sat) - FILT_W'(r_dc_prev);
    end

    // mean = sign(sum) * (|sum| / fill)
    always_comb begin
        sum_mag  = win_sum[SUM_W-1] ? SUM_W'(-win_sum) : SUM_W'(win_sum);
        mean_mag = signed'(div_quot[SUM_W-1:0]);
        mean     = win_sum[SUM_W-1] ? -mean_mag : mean_mag;
        md_raw   = (SUM_W+1)'(mean) - (SUM_W+1)'(r_filt);
        md       = sat_s24(32'(md_raw));
    end

    // peak edge and 16-bit wrapped interval
    always_comb begin
        rise      = (r_md > r_thr) && !r_armed;
        delta     = r_time[MIN_W-1:0] - r_last[MIN_W-1:0];
        take_beat = rise && (delta > r_min);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    n_state = ST_DCDIV;
                end
            end
            ST_DCDIV: begin
                if (div_done) begin
                    n_state = ST_WIN;
                end
            end
            ST_WIN: begin
                n_state = ST_MEAN;
            end
            ST_MEAN: begin
                if (div_done) begin
                    n_state = ST_DET;
                end
            end
            ST_DET: begin
                n_state = take_beat ? ST_BPM : ST_DONE;
            end
            ST_BPM: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs: unit starts and divider operand select
    always_comb begin
        mul_start    = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        win_wr       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                mul_start = in_acc;
            end
            ST_MUL: begin
                div_start    = mul_done;
                div_dividend = DIVD_W'(mul_prod);
                div_divisor  = DIVS_W'(DC_DIVISOR);
            end
            ST_DCDIV: begin
                win_wr = div_done;
            end
            ST_WIN: begin
                div_start    = 1'b1;
                div_dividend = DIVD_W'(sum_mag);
                div_divisor  = DIVS_W'(win_fill);
            end
            ST_DET: begin
                div_start    = take_beat;
                div_dividend = DIVD_W'(BPM_NUM);
                div_divisor  = DIVS_W'(delta);
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_thr       <= '0;
            r_min       <= MIN_W'(MIN_RST);
            r_alpha     <= ALPHA_W'(ALPHA_RST);
            r_dc_prev   <= '0;
            r_armed     <= 1'b0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_THRESHOLD:    r_thr   <= signed'(i_cfg_data[THR_W-1:0]);
                    CFG_MIN_INTERVAL: r_min   <= i_cfg_data[MIN_W-1:0];
                    CFG_ALPHA:        r_alpha <= i_cfg_data[ALPHA_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_state == ST_DCDIV && div_done) begin
                r_dc_prev <= w_sat;
            end

            // arm on a rise, disarm only strictly below threshold
            if (r_state == ST_DET) begin
                if (rise) begin
                    r_armed <= 1'b1;
                    if (take_beat) begin
                        r_last <= r_time;
                    end
                end else if (r_md < r_thr) begin
                    r_armed <= 1'b0;
                end
            end

            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_red_sample;
            r_time   <= i_time_ms;
        end
        if (r_state == ST_DCDIV && div_done) begin
            r_filt <= filt;
        end
        if (r_state == ST_MEAN && div_done) begin
            r_md <= md;
        end
        if (r_state == ST_DET) begin
            r_beat <= take_beat;
            r_bpm  <= '0;
        end
        if (r_state == ST_BPM && div_done) begin
            r_bpm <= div_quot[BPM_W-1:0];
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_md   <= r_md;
            r_out_beat <= r_beat;
            r_out_bpm  <= r_bpm;
        end
    end

    prbd_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mplier (r_alpha),
        .i_mcand  (dc_mag),
        .o_prod   (mul_prod),
        .o_done   (mul_done)
    );

    prbd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quot     (div_quot),
        .o_done     (div_done)
    );

    prbd_win u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (win_wr),
        .i_data  (filt),
        .o_sum   (win_sum),
        .o_fill  (win_fill)
    );

    assign o_out_valid        = r_out_valid;
    assign o_mean_diff        = r_out_md;
    assign o_beat             = r_out_beat;
    assign o_beats_per_minute = r_out_bpm;

endmodule

@@ hw/rtl/prbd_chk.sv @@
// ----------------------------------------------------------------------------
// prbd_chk
// port-level checks on the beat detector, bound to the top level
// ----------------------------------------------------------------------------
module prbd_chk (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   o_in_ready,
    input  logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    input  logic signed [prbd_pkg::MD_W-1:0]       o_mean_diff,
    input  logic                                   o_beat,
    input  logic [prbd_pkg::BPM_W-1:0]             o_beats_per_minute
);
    import prbd_pkg::*;

    // a pending result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_mean_diff)
            && $stable(o_beat) && $stable(o_beats_per_minute))
        else $error("result word changed while stalled");

    // one word in flight: ready drops right after a word is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a word is in flight");

    // no rate without a beat
    a_bpm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_beat |-> o_beats_per_minute == '0)
        else $error("rate reported without a beat");

    // rate never above the one-millisecond bound
    a_bpm_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_beats_per_minute <= BPM_W'(BPM_NUM))
        else $error("rate above bound");

endmodule

bind pulse_rate_beat_detector_top prbd_chk u_prbd_chk (.*);
